[rtl/wbt_pkg.sv]
// ---------------------------------------------------------------------------
// wbt_pkg - word boundary tokenizer package
// Character constants, byte classes and beat field widths for the tokenizer.
// ---------------------------------------------------------------------------
package wbt_pkg;

    // beat field widths
    localparam int BYTE_W   = 8;
    localparam int OFFS_W   = 16;
    localparam int FIELD_W  = 16;
    localparam int M_DATA_W = 3 * FIELD_W;

    // characters with a special role
    localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_PERIOD     = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_HYPHEN     = 8'h2D;

    // letter, digit or underscore: may open a word
    function automatic logic is_word_begin(input logic [BYTE_W-1:0] c);
        logic upper;
        logic lower;
        logic digit;
        upper = (c >= 8'h41) && (c <= 8'h5A);
        lower = (c >= 8'h61) && (c <= 8'h7A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        return upper || lower || digit || (c == CHAR_UNDERSCORE);
    endfunction

    // any byte that keeps an open word going
    function automatic logic is_word_middle(input logic [BYTE_W-1:0] c);
        return is_word_begin(c) || (c == CHAR_PERIOD) || (c == CHAR_HYPHEN);
    endfunction

endpackage

[rtl/word_boundary_tokenizer.sv]
// ---------------------------------------------------------------------------
// word_boundary_tokenizer - streaming word finder
// Finds words in a byte stream and reports start, trimmed length and number.
// ---------------------------------------------------------------------------
// usage
//   s_ channel: one text byte per beat in s_tdata, s_tlast on the last byte of
//   a text. s_tlast closes any open word and restarts offsets and numbering.
//   m_ channel: one beat per finished word; s_tdata-side word ends are
//   reported on the beat of the first non-word byte or of the s_tlast byte.
//   m_tdata carries start offset, trimmed length and word number, m_tuser
//   flags words of MAX_WORD bytes or more. offsets and counts saturate.
// timing
//   a byte accepted lands in the input register, then is classified
//   and folded into the word state as it leaves that register, which also loads the
//   result register that drives m_tvalid.
//   one byte per clock sustained; the input register and the result
//   register each advance whenever the result register is empty or taken.
// reset and stall
//   aresetn low empties both registers and clears the word state.
//   while m_tvalid waits on m_tready, one more byte is held in the input
//   register and s_tready drops until the result is taken.
// ---------------------------------------------------------------------------
module word_boundary_tokenizer #(
    parameter int MAX_WORD = 32,
    parameter int MAX_TEXT = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] word_start, [31:16] word_length,
                                   // [47:32] word_number
    output logic [0:0]  m_tuser    // [0] too_long
);

    localparam int OW = wbt_pkg::OFFS_W;
    localparam logic [OW-1:0] OFFSET_MAX = OW'(MAX_TEXT - 1);
    localparam logic [OW:0]   LONG_LEN   = (OW + 1)'(MAX_WORD);
    localparam logic [OW-1:0] COUNT_MAX  = {OW{1'b1}};

    // input register
    logic                         in_valid_reg;
    logic [wbt_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                         in_last_reg;

    // word state
    logic          inside_word_reg, inside_word_next;
    logic [OW-1:0] word_begin_reg,  word_begin_next;
    logic [OW:0]   trimmed_end_reg, trimmed_end_next;
    logic [OW-1:0] byte_offset_reg, byte_offset_next;
    logic [OW-1:0] word_count_reg,  word_count_next;

    // result register
    logic                          out_valid_reg;
    logic [wbt_pkg::M_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                          out_long_reg, out_long_next;
    logic                          emit;

    logic out_free;
    logic stage_fire;

    assign out_free   = !out_valid_reg || m_tready;
    assign stage_fire = in_valid_reg && out_free;
    assign s_tready   = !in_valid_reg || out_free;

    // input register load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // word state update and result forming
    always_comb begin
        logic          cb;
        logic          cm;
        logic [OW:0]   len;
        logic [OW:0]   pos_plus;

        cb       = wbt_pkg::is_word_begin(in_byte_reg);
        cm       = wbt_pkg::is_word_middle(in_byte_reg);
        pos_plus = {1'b0, byte_offset_reg} + 1'b1;

        inside_word_next = inside_word_reg;
        word_begin_next  = word_begin_reg;
        trimmed_end_next = trimmed_end_reg;
        word_count_next  = word_count_reg;
        emit             = 1'b0;

        if (inside_word_reg) begin
            if (cm) begin
                if (cb) begin
                    trimmed_end_next = pos_plus;
                end
            end else begin
                emit             = 1'b1;
                inside_word_next = 1'b0;
            end
        end else if (cb) begin
            inside_word_next = 1'b1;
            word_begin_next  = byte_offset_reg;
            trimmed_end_next = pos_plus;
            if (word_count_reg != COUNT_MAX) begin
                word_count_next = word_count_reg + 1'b1;
            end
        end

        // end of text closes an open word on the same beat
        if (in_last_reg && inside_word_next) begin
            emit = 1'b1;
        end

        // result fields from the state before end-of-text clearing
        len = trimmed_end_next - {1'b0, word_begin_next};
        out_data_next[15:0]  = word_begin_next;
        out_data_next[31:16] = len[OW] ? {OW{1'b1}} : len[OW-1:0];
        out_data_next[47:32] = word_count_next;
        out_long_next        = (len >= LONG_LEN);

        // offset advance or restart
        byte_offset_next = byte_offset_reg;
        if (in_last_reg) begin
            inside_word_next = 1'b0;
            byte_offset_next = '0;
            word_count_next  = '0;
        end else if (byte_offset_reg < OFFSET_MAX) begin
            byte_offset_next = byte_offset_reg + 1'b1;
        end
    end

    // word state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_word_reg <= 1'b0;
            word_begin_reg  <= '0;
            trimmed_end_reg <= '0;
            byte_offset_reg <= '0;
            word_count_reg  <= '0;
        end else if (stage_fire) begin
            inside_word_reg <= inside_word_next;
            word_begin_reg  <= word_begin_next;
            trimmed_end_reg <= trimmed_end_next;
            byte_offset_reg <= byte_offset_next;
            word_count_reg  <= word_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= stage_fire && emit;
        end
        if (stage_fire && emit) begin
            out_data_reg <= out_data_next;
            out_long_reg <= out_long_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_long_reg;

    // a reported word always holds at least one character
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[31:16] != '0))
        else $error("word reported with zero length");

    // word numbers are 1-based
    a_number_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[47:32] != '0))
        else $error("word reported with number zero");

    // long flag agrees with the reported length
    a_long_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_long_reg == ({1'b0, out_data_reg[31:16]} >= LONG_LEN)))
        else $error("long flag disagrees with length");

    // end of text leaves no word open and restarts the offset
    a_text_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_fire && in_last_reg) |=> (!inside_word_reg && (byte_offset_reg == '0)))
        else $error("state not restarted after end of text");

endmodule
